@@ design/fdr_pkg.sv @@
// fdr_pkg: shared widths, constants and register indexes for the fresnel reflectance unit
// no dependencies
package fdr_pkg;

  localparam int COS_W  = 16;
  localparam int ETA_W  = 15;
  localparam int REFL_W = 17;

  localparam logic signed [COS_W-1:0] ONE_Q14 = 16'sd16384;
  localparam logic [REFL_W-1:0] ONE_Q16 = 17'd65536;

  localparam logic [ETA_W-1:0] ETA_I_RESET = 15'd8192;
  localparam logic [ETA_W-1:0] ETA_T_RESET = 15'd12288;

  typedef enum logic [0:0] {
    REG_ETA_INCIDENT    = 1'b0,
    REG_ETA_TRANSMITTED = 1'b1
  } cfg_reg_t;

  // squared transmitted cosine divider, quotient reaches exactly one at normal incidence
  localparam int CT2_NUM_W = 58;
  localparam int CT2_DEN_W = 30;
  localparam int CT2_QUO_W = 29;
  // amplitude ratio dividers
  localparam int AMP_NUM_W = 49;
  localparam int AMP_DEN_W = 33;
  localparam int AMP_QUO_W = 17;
  // square root input, even width so the root holds one in Q.16
  localparam int SQRT_IN_W = 34;
  // side data carried alongside the squared cosine
  localparam int SIDE_W = 1 + 3 * ETA_W;

endpackage

@@ design/fdr_div.sv @@
// fdr_div: pipelined restoring divider, one quotient bit per stage
// needs fdr_pkg; dividend must stay below divisor shifted by the quotient width
module fdr_div import fdr_pkg::*; #(
  parameter int NUM_W = CT2_NUM_W,
  parameter int DEN_W = CT2_DEN_W,
  parameter int QUO_W = CT2_QUO_W,
  parameter int TAG_W = SIDE_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [QUO_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  localparam int W = (NUM_W > DEN_W + QUO_W) ? NUM_W : DEN_W + QUO_W;

  logic [W-1:0]     rem_src [0:QUO_W-1];
  logic [DEN_W-1:0] den_src [0:QUO_W-1];
  logic [QUO_W-1:0] quo_src [0:QUO_W-1];
  logic [TAG_W-1:0] tag_src [0:QUO_W-1];
  logic             vld_src [0:QUO_W-1];

  logic [W-1:0]     rem_next [0:QUO_W-1];
  logic [QUO_W-1:0] quo_next [0:QUO_W-1];

  logic [W-1:0]     rem_r [0:QUO_W-1];
  logic [DEN_W-1:0] den_r [0:QUO_W-1];
  logic [QUO_W-1:0] quo_r [0:QUO_W-1];
  logic [TAG_W-1:0] tag_r [0:QUO_W-1];
  logic             vld_r [0:QUO_W-1];

  always_comb begin
    rem_src[0] = W'(num);
    den_src[0] = den;
    quo_src[0] = '0;
    tag_src[0] = tag;
    vld_src[0] = in_valid;
    for (int k = 1; k < QUO_W; k++) begin
      rem_src[k] = rem_r[k-1];
      den_src[k] = den_r[k-1];
      quo_src[k] = quo_r[k-1];
      tag_src[k] = tag_r[k-1];
      vld_src[k] = vld_r[k-1];
    end
  end

  // trial subtract of the shifted divisor
  always_comb begin
    logic [W-1:0] shifted;
    shifted = '0;
    for (int k = 0; k < QUO_W; k++) begin
      shifted = W'(den_src[k]) << (QUO_W - 1 - k);
      if (rem_src[k] >= shifted) begin
        rem_next[k] = rem_src[k] - shifted;
        quo_next[k] = quo_src[k] | (QUO_W'(1) << (QUO_W - 1 - k));
      end else begin
        rem_next[k] = rem_src[k];
        quo_next[k] = quo_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < QUO_W; k++) vld_r[k] <= vld_src[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < QUO_W; k++) begin
        rem_r[k] <= rem_next[k];
        den_r[k] <= den_src[k];
        quo_r[k] <= quo_next[k];
        tag_r[k] <= tag_src[k];
      end
    end
  end

  assign out_valid = vld_r[QUO_W-1];
  assign quo       = quo_r[QUO_W-1];
  assign out_tag   = tag_r[QUO_W-1];

endmodule

@@ design/fdr_sqrt.sv @@
// fdr_sqrt: pipelined floor square root, one result bit per stage
// needs fdr_pkg; input width must be even
module fdr_sqrt import fdr_pkg::*; #(
  parameter int IN_W  = SQRT_IN_W,
  parameter int TAG_W = SIDE_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  logic                in_valid,
  input  logic [IN_W-1:0]     radicand,
  input  logic [TAG_W-1:0]    tag,
  output logic                out_valid,
  output logic [IN_W/2-1:0]   root,
  output logic [TAG_W-1:0]    out_tag
);

  localparam int OUT_W = IN_W / 2;
  localparam int W     = IN_W + 2;

  logic [W-1:0]     rem_src  [0:OUT_W-1];
  logic [OUT_W-1:0] res_src  [0:OUT_W-1];
  logic [TAG_W-1:0] tag_src  [0:OUT_W-1];
  logic             vld_src  [0:OUT_W-1];
  logic [W-1:0]     rem_next [0:OUT_W-1];
  logic [OUT_W-1:0] res_next [0:OUT_W-1];

  logic [W-1:0]     rem_r [0:OUT_W-1];
  logic [OUT_W-1:0] res_r [0:OUT_W-1];
  logic [TAG_W-1:0] tag_r [0:OUT_W-1];
  logic             vld_r [0:OUT_W-1];

  always_comb begin
    rem_src[0] = W'(radicand);
    res_src[0] = '0;
    tag_src[0] = tag;
    vld_src[0] = in_valid;
    for (int k = 1; k < OUT_W; k++) begin
      rem_src[k] = rem_r[k-1];
      res_src[k] = res_r[k-1];
      tag_src[k] = tag_r[k-1];
      vld_src[k] = vld_r[k-1];
    end
  end

  // (r + 2^b)^2 - r^2 = r*2^(b+1) + 2^(2b)
  always_comb begin
    logic [W-1:0] inc;
    inc = '0;
    for (int k = 0; k < OUT_W; k++) begin
      inc = (W'(res_src[k]) << (OUT_W - k)) | (W'(1) << (2 * (OUT_W - 1 - k)));
      if (rem_src[k] >= inc) begin
        rem_next[k] = rem_src[k] - inc;
        res_next[k] = res_src[k] | (OUT_W'(1) << (OUT_W - 1 - k));
      end else begin
        rem_next[k] = rem_src[k];
        res_next[k] = res_src[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < OUT_W; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      for (int k = 0; k < OUT_W; k++) vld_r[k] <= vld_src[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < OUT_W; k++) begin
        rem_r[k] <= rem_next[k];
        res_r[k] <= res_next[k];
        tag_r[k] <= tag_src[k];
      end
    end
  end

  assign out_valid = vld_r[OUT_W-1];
  assign root      = res_r[OUT_W-1];
  assign out_tag   = tag_r[OUT_W-1];

endmodule

@@ design/fresnel_dielectric_reflectance_unit.sv @@
// fresnel_dielectric_reflectance_unit: unpolarised dielectric fresnel reflectance, pipelined
// one request per cycle sustained while no shown result is stalled; the pipe holds the
// 29-stage cosine divider, 17-stage square root and 17-stage amplitude dividers
// the whole pipe advances together and freezes only while a shown result is stalled
// synchronous reset clears all valid bits and loads the index registers with their defaults
// needs fdr_pkg, fdr_div, fdr_sqrt
module fresnel_dielectric_reflectance_unit import fdr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  // configuration
  input  logic                    cfg_write,
  input  logic [0:0]              cfg_index,
  input  logic [ETA_W-1:0]        cfg_data,
  // request side
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [COS_W-1:0] cos_incident,
  // result side
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic [REFL_W-1:0]       reflectance,
  output logic                    total_internal
);

  logic en;
  logic [ETA_W-1:0] eta_incident;
  logic [ETA_W-1:0] eta_transmitted;

  // global advance: only a held result blocks the pipe
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      eta_incident    <= ETA_I_RESET;
      eta_transmitted <= ETA_T_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_ETA_INCIDENT:    eta_incident    <= cfg_data;
        REG_ETA_TRANSMITTED: eta_transmitted <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: clamp to plus/minus one, swap indices when the cosine is not positive
  logic signed [COS_W-1:0] cos_clamped;
  logic signed [COS_W-1:0] cos_neg;
  logic                    s1_valid;
  logic [ETA_W-1:0]        s1_c, s1_ei, s1_et;

  always_comb begin
    if (cos_incident > ONE_Q14)       cos_clamped = ONE_Q14;
    else if (cos_incident < -ONE_Q14) cos_clamped = -ONE_Q14;
    else                              cos_clamped = cos_incident;
    cos_neg = -cos_clamped;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (cos_clamped <= 0) begin
        s1_c  <= cos_neg[ETA_W-1:0];
        s1_ei <= eta_transmitted;
        s1_et <= eta_incident;
      end else begin
        s1_c  <= cos_clamped[ETA_W-1:0];
        s1_ei <= eta_incident;
        s1_et <= eta_transmitted;
      end
    end
  end

  // stage 2: squares of cosine and indices
  logic                 s2_valid;
  logic [28:0]          s2_c2;
  logic [2*ETA_W-1:0]   s2_ei2, s2_et2;
  logic [ETA_W-1:0]     s2_c, s2_ei, s2_et;
  logic [2*ETA_W-1:0]   c_sq;

  assign c_sq = s1_c * s1_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s2_c2  <= c_sq[28:0];
      s2_ei2 <= s1_ei * s1_ei;
      s2_et2 <= s1_et * s1_et;
      s2_c   <= s1_c;
      s2_ei  <= s1_ei;
      s2_et  <= s1_et;
    end
  end

  // stage 3: ei^2 * c^2 split in two partial products, squared index difference
  logic                     s3_valid;
  logic [44:0]              s3_mhi;
  logic [43:0]              s3_mlo;
  logic signed [2*ETA_W:0]  s3_base;
  logic [2*ETA_W-1:0]       s3_et2;
  logic [ETA_W-1:0]         s3_c, s3_ei, s3_et;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_mhi  <= s2_ei2 * s2_c2[28:14];
      s3_mlo  <= s2_ei2 * s2_c2[13:0];
      s3_base <= $signed({1'b0, s2_et2}) - $signed({1'b0, s2_ei2});
      s3_et2  <= s2_et2;
      s3_c    <= s2_c;
      s3_ei   <= s2_ei;
      s3_et   <= s2_et;
    end
  end

  // stage 4: et^2*2^28 - ei^2*(2^28 - c^2), total internal when not positive
  logic                 s4_valid;
  logic [60:0]          s4_num;
  logic [2*ETA_W-1:0]   s4_et2;
  logic [ETA_W-1:0]     s4_c, s4_ei, s4_et;
  logic                 s4_tir;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_num <= {{2{s3_base[2*ETA_W]}}, s3_base, 28'b0}
              + {2'b0, s3_mhi, 14'b0}
              + {17'b0, s3_mlo};
      s4_et2 <= s3_et2;
      s4_c   <= s3_c;
      s4_ei  <= s3_ei;
      s4_et  <= s3_et;
    end
  end

  assign s4_tir = s4_num[60] || (s4_num == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  // squared transmitted cosine, Q.28
  logic                 ct2_valid;
  logic [CT2_QUO_W-1:0] ct2;
  logic [SIDE_W-1:0]    ct2_side;

  fdr_div #(
    .NUM_W (CT2_NUM_W),
    .DEN_W (CT2_DEN_W),
    .QUO_W (CT2_QUO_W),
    .TAG_W (SIDE_W)
  ) u_ct2_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s4_valid),
    .num       (s4_num[CT2_NUM_W-1:0]),
    .den       (s4_et2),
    .tag       ({s4_tir, s4_c, s4_ei, s4_et}),
    .out_valid (ct2_valid),
    .quo       (ct2),
    .out_tag   (ct2_side)
  );

  // transmitted cosine, Q.16
  logic                   ct_valid;
  logic [SQRT_IN_W/2-1:0] cos_t;
  logic [SIDE_W-1:0]      ct_side;

  fdr_sqrt #(
    .IN_W  (SQRT_IN_W),
    .TAG_W (SIDE_W)
  ) u_ct_sqrt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (ct2_valid),
    .radicand  (SQRT_IN_W'({ct2, 4'b0})),
    .tag       (ct2_side),
    .out_valid (ct_valid),
    .root      (cos_t),
    .out_tag   (ct_side)
  );

  logic             ct_tir;
  logic [ETA_W-1:0] ct_c, ct_ei, ct_et;
  logic [16:0]      cos_i;

  assign {ct_tir, ct_c, ct_ei, ct_et} = ct_side;
  assign cos_i = {ct_c, 2'b0};

  // stage 5: amplitude numerator and denominator terms
  logic        s5_valid, s5_tir;
  logic [31:0] s5_p1, s5_p2;
  logic [31:0] s5_q1, s5_q2;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_p1  <= ct_et * cos_i;
      s5_q1  <= ct_ei * cos_t;
      s5_p2  <= ct_ei * cos_i;
      s5_q2  <= ct_et * cos_t;
      s5_tir <= ct_tir;
    end
  end

  // stage 6: rounded ratio dividend |p-q|*2^16 + (p+q)/2, divisor p+q
  logic [AMP_DEN_W-1:0] sum1, sum2;
  logic [31:0]          dif1, dif2;

  always_comb begin
    sum1 = AMP_DEN_W'(s5_p1) + AMP_DEN_W'(s5_q1);
    sum2 = AMP_DEN_W'(s5_p2) + AMP_DEN_W'(s5_q2);
    dif1 = (s5_p1 >= s5_q1) ? s5_p1 - s5_q1 : s5_q1 - s5_p1;
    dif2 = (s5_p2 >= s5_q2) ? s5_p2 - s5_q2 : s5_q2 - s5_p2;
  end

  logic                 s6_valid, s6_tir, s6_z1, s6_z2;
  logic [AMP_NUM_W-1:0] s6_n1, s6_n2;
  logic [AMP_DEN_W-1:0] s6_d1, s6_d2;

  always_ff @(posedge clk) begin
    if (en) begin
      s6_n1  <= {1'b0, dif1, 16'b0} + AMP_NUM_W'(sum1 >> 1);
      s6_n2  <= {1'b0, dif2, 16'b0} + AMP_NUM_W'(sum2 >> 1);
      s6_d1  <= sum1;
      s6_d2  <= sum2;
      s6_z1  <= (sum1 == '0);
      s6_z2  <= (sum2 == '0);
      s6_tir <= s5_tir;
    end
  end

  // amplitude ratios, Q.16
  logic                 r1_valid, r2_valid;
  logic [AMP_QUO_W-1:0] r1, r2;
  logic [1:0]           r1_tag;
  logic [0:0]           r2_tag;

  fdr_div #(
    .NUM_W (AMP_NUM_W),
    .DEN_W (AMP_DEN_W),
    .QUO_W (AMP_QUO_W),
    .TAG_W (2)
  ) u_par_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_valid),
    .num       (s6_n1),
    .den       (s6_d1),
    .tag       ({s6_tir, s6_z1}),
    .out_valid (r1_valid),
    .quo       (r1),
    .out_tag   (r1_tag)
  );

  fdr_div #(
    .NUM_W (AMP_NUM_W),
    .DEN_W (AMP_DEN_W),
    .QUO_W (AMP_QUO_W),
    .TAG_W (1)
  ) u_perp_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s6_valid),
    .num       (s6_n2),
    .den       (s6_d2),
    .tag       (s6_z2),
    .out_valid (r2_valid),
    .quo       (r2),
    .out_tag   (r2_tag)
  );

  // stage 7: squared amplitudes
  logic        s7_valid, s7_tir, s7_z1, s7_z2;
  logic [33:0] s7_rr1, s7_rr2;

  always_ff @(posedge clk) begin
    if (en) begin
      s7_rr1 <= r1 * r1;
      s7_rr2 <= r2 * r2;
      s7_tir <= r1_tag[1];
      s7_z1  <= r1_tag[0];
      s7_z2  <= r2_tag[0];
    end
  end

  // output stage: round, average, saturate, force one on total internal; zero denominator counts as one
  logic [33:0]       rr1_rnd, rr2_rnd;
  logic [REFL_W-1:0] sq1, sq2;
  logic [REFL_W:0]   mean;
  logic [REFL_W-1:0] refl_next;

  always_comb begin
    rr1_rnd = s7_rr1 + 34'd32768;
    rr2_rnd = s7_rr2 + 34'd32768;
    sq1  = s7_z1 ? ONE_Q16 : rr1_rnd[32:16];
    sq2  = s7_z2 ? ONE_Q16 : rr2_rnd[32:16];
    mean = ({1'b0, sq1} + {1'b0, sq2} + 18'd1) >> 1;
    if (s7_tir || mean > {1'b0, ONE_Q16}) refl_next = ONE_Q16;
    else                                  refl_next = mean[REFL_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      reflectance    <= refl_next;
      total_internal <= s7_tir;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_valid  <= 1'b0;
      s6_valid  <= 1'b0;
      s7_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      s5_valid  <= ct_valid;
      s6_valid  <= s5_valid;
      s7_valid  <= r1_valid && r2_valid;
      out_valid <= s7_valid;
    end
  end

endmodule

@@ tb/tb_top.sv @@
// tb_top: self-checking testbench for the fresnel dielectric reflectance unit
// drives cosine requests and index writes, predicts each result in fixed point and scores it
// depends on fdr_pkg and the fresnel_dielectric_reflectance_unit rtl
`timescale 1ns / 100ps

class fresnel_scoreboard;
  bit [16:0] refl_q[$];
  bit        tir_q[$];
  int        errors;
  int        checked;
  int        tir_seen;
  logic [14:0] eta_i;
  logic [14:0] eta_t;

  function new();
    errors = 0;
    checked = 0;
    tir_seen = 0;
    eta_i = fdr_pkg::ETA_I_RESET;
    eta_t = fdr_pkg::ETA_T_RESET;
  endfunction

  function void set_index(fdr_pkg::cfg_reg_t idx, logic [14:0] val);
    if (idx == fdr_pkg::REG_ETA_INCIDENT) eta_i = val;
    else eta_t = val;
  endfunction

  static function longint unsigned root_floor(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  static function longint unsigned amp_squared(longint unsigned p, longint unsigned q);
    longint unsigned s;
    longint unsigned d;
    longint unsigned r;
    s = p + q;
    d = (p >= q) ? p - q : q - p;
    if (s == 0) return 65536;
    r = ((d << 16) + (s >> 1)) / s;
    return (r * r + 32768) >> 16;
  endfunction

  // note an accepted cosine request and queue its expected reflectance
  function void note_request(logic signed [15:0] cosv);
    int              cs;
    longint unsigned ni, nt, c, s2, lhs, rhs, ct2, ct, ci, r;
    cs = cosv;
    ni = eta_i;
    nt = eta_t;
    if (cs > 16384) cs = 16384;
    if (cs < -16384) cs = -16384;
    if (cs <= 0) begin
      ni = eta_t;
      nt = eta_i;
      c = -cs;
    end else begin
      c = cs;
    end
    s2 = (64'd1 << 28) - c * c;
    lhs = ni * ni * s2;
    rhs = (nt * nt) << 28;
    if (lhs >= rhs) begin
      refl_q.push_back(17'd65536);
      tir_q.push_back(1'b1);
      return;
    end
    ct2 = (rhs - lhs) / (nt * nt);
    ct = root_floor(ct2 << 4);
    ci = c << 2;
    r = amp_squared(nt * ci, ni * ct) + amp_squared(ni * ci, nt * ct);
    r = (r + 1) >> 1;
    if (r > 65536) r = 65536;
    refl_q.push_back(r[16:0]);
    tir_q.push_back(1'b0);
  endfunction

  task report(string what);
    errors++;
    $display("mismatch: %s", what);
  endtask

  task check_result(logic [16:0] refl, logic tir);
    bit [16:0] er;
    bit        et;
    checked++;
    if (refl_q.size() == 0) begin
      report("result with nothing outstanding");
      return;
    end
    er = refl_q.pop_front();
    et = tir_q.pop_front();
    if (tir) tir_seen++;
    if (refl !== er)
      report($sformatf("reflectance got %0d want %0d", refl, er));
    if (tir !== et)
      report($sformatf("total_internal got %0b want %0b", tir, et));
  endtask
endclass

module tb_top;
  import fdr_pkg::*;

  localparam int LATENCY   = 71;
  localparam int CYCLE_CAP = 400000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [0:0] cfg_index = 1'b0;
  logic [ETA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COS_W-1:0] cos_incident = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [REFL_W-1:0] reflectance;
  logic total_internal;

  fresnel_scoreboard fresnel_sb = new();
  int  cycle_count = 0;
  bit  calm_phase = 1'b0;   // no idling on either side
  bit  hold_off = 1'b0;     // receiver freezes for a long stretch
  int  requests_sent = 0;

  fresnel_dielectric_reflectance_unit dut (.*);

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // watchdog on the cycle counter
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stall, a long hold-off when asked, score every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      fresnel_sb.check_result(reflectance, total_internal);
    if (hold_off) out_stall <= 1'b1;
    else if (calm_phase) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 29);
  end

  // long hold-off counted here, while the sender keeps offering requests
  initial begin
    wait (requests_sent >= 300);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (250) @(posedge clk);
    hold_off <= 1'b0;
  end

  // offer one cosine and wait until it is taken
  task automatic send_cos(logic signed [15:0] v);
    if (!calm_phase)
      while ($urandom_range(99) < 29) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    in_valid <= 1'b1;
    cos_incident <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    fresnel_sb.note_request(v);
    requests_sent++;
  endtask

  // wait for the queue to drain and the pipe to empty before touching the indices
  task automatic drain();
    in_valid <= 1'b0;
    while (fresnel_sb.refl_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_index(cfg_reg_t idx, logic [14:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    fresnel_sb.set_index(idx, val);
    @(posedge clk);
  endtask

  // mostly in-range cosines, with a share of wild ones and exact extremes
  function automatic logic signed [15:0] pick_cos();
    int k;
    k = $urandom_range(99);
    if (k < 70) return COS_W'($urandom_range(32768) - 16384);
    if (k < 80) return COS_W'($urandom_range(2) * 16384 - 16384);
    if (k < 85) return COS_W'($urandom_range(3) - 1);
    return COS_W'($urandom());
  endfunction

  initial begin
    logic signed [15:0] directed[$];
    logic [14:0] eta_sets[6][2];
    int n_rand;
    directed = '{16'sd16384, -16'sd16384, 16'sd0, 16'sd1, -16'sd1, 16'sh7fff,
                 16'sh8000, 16'sd16385, -16'sd16385, 16'sd8192, -16'sd8192,
                 16'sd11585, -16'sd11585, 16'sd100, -16'sd100, 16'sh5555,
                 16'shaaaa, 16'sd16383, -16'sd16383, 16'sd2};
    eta_sets = '{'{15'd8192, 15'd12288}, '{15'd4096, 15'd32767},
                 '{15'd32767, 15'd4096}, '{15'd10000, 15'd10000},
                 '{15'd0, 15'd8192}, '{15'd32767, 15'd0}};
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed sweep at reset indices
    foreach (directed[i]) send_cos(directed[i]);

    // several index settings, extremes and out-of-range zeros among them
    foreach (eta_sets[s]) begin
      drain();
      write_index(REG_ETA_INCIDENT, eta_sets[s][0]);
      write_index(REG_ETA_TRANSMITTED, eta_sets[s][1]);
      foreach (directed[i]) if (i < 8) send_cos(directed[i]);
      n_rand = (s == 0) ? 700 : 150;
      calm_phase = (s == 1);
      for (int i = 0; i < n_rand; i++) send_cos(pick_cos());
      calm_phase = 1'b0;
    end

    // random indices to reach every bit
    for (int s = 0; s < 4; s++) begin
      drain();
      write_index(REG_ETA_INCIDENT, ETA_W'($urandom()));
      write_index(REG_ETA_TRANSMITTED, ETA_W'($urandom()));
      for (int i = 0; i < 60; i++) send_cos(pick_cos());
    end

    drain();
    $display("covered %0d requests over 11 index settings, %0d results scored",
             requests_sent, fresnel_sb.checked);
    $display("%0d results showed total internal reflection", fresnel_sb.tir_seen);
    if (fresnel_sb.errors == 0 && fresnel_sb.refl_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
